// File: sv/reduced_fraction_accumulator_assert.svh
// Assertion macros used by the controller module.
`ifndef REDUCED_FRACTION_ACCUMULATOR_ASSERT_SVH
`define REDUCED_FRACTION_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Check that an implication holds in the same cycle.
`define RFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that an implication holds in the next cycle.
`define RFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RFA_ASSERT_NOW(lbl, ante, cons, msg)
`define RFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/rfa_pkg.sv
package rfa_pkg;
	localparam int VALUE_WIDTH = 32;
	localparam int SW = 2 * VALUE_WIDTH + 1;
	localparam int MW = 2 * VALUE_WIDTH;
	localparam int KW = $clog2(MW + 1);

	typedef enum logic [1:0] {
		ACT_ADD  = 2'd0,
		ACT_DIV  = 2'd1,
		ACT_LOAD = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MUL_HN_D = 2'd0,
		MUL_HD_C = 2'd1,
		MUL_HD_D = 2'd2,
		MUL_HD_Q = 2'd3
	} mul_sel_t;

	typedef enum logic [2:0] {
		NUM_HOLD = 3'd0,
		NUM_PROD = 3'd1,
		NUM_ADD  = 3'd2,
		NUM_HN   = 3'd3,
		NUM_C    = 3'd4
	} num_op_t;

	typedef enum logic [1:0] {
		DEN_HOLD = 2'd0,
		DEN_PROD = 2'd1,
		DEN_D    = 2'd2
	} den_op_t;

	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		num_op_t  num_op;
		den_op_t  den_op;
		logic     gcd_init;
		logic     gcd_step;
		logic     div_init;
		logic     div_step;
		logic     commit;
	} rfa_cmd_t;

	typedef struct packed {
		action_t act;
		logic    gcd_done;
		logic    div_done;
		logic    out_free;
	} rfa_status_t;
endpackage

// File: sv/rfa_datapath.sv
module rfa_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  rfa_pkg::rfa_cmd_t                      cmd,
	output rfa_pkg::rfa_status_t                   status,
	input  logic [1:0]                             action,
	input  logic signed [rfa_pkg::VALUE_WIDTH-1:0] in_numerator,
	input  logic signed [rfa_pkg::VALUE_WIDTH-1:0] in_denominator,
	input  logic signed [rfa_pkg::VALUE_WIDTH-1:0] divisor,
	input  logic                                   out_ready,
	output logic                                   out_valid,
	output logic signed [rfa_pkg::VALUE_WIDTH-1:0] sum_numerator,
	output logic [rfa_pkg::VALUE_WIDTH-2:0]        sum_denominator,
	output logic                                   zero_denominator,
	output logic                                   overflow
);
	import rfa_pkg::*;

	localparam int W = VALUE_WIDTH;

	action_t                act_q;
	logic signed [W-1:0]    c_q, d_q, q_q;
	logic signed [W-1:0]    hn_q;
	logic [W-2:0]           hd_q;
	logic signed [MW-1:0]   prod_q;
	logic signed [SW-1:0]   num_q, den_q;
	logic                   sign_q;
	logic [MW-1:0]          mn_q, md_q, ga_q, gb_q, g_q, qn_q, qd_q, rn_q, rd_q;
	logic [KW-1:0]          gk_q, cnt_q;
	logic                   out_valid_q;

	// Shared multiplier
	logic signed [W-1:0]  mul_a, mul_b, hd_ext;
	logic signed [MW-1:0] mul_p;
	assign hd_ext = signed'({1'b0, hd_q});
	always_comb begin
		unique case (cmd.mul_sel)
			MUL_HN_D: begin mul_a = hn_q;   mul_b = d_q; end
			MUL_HD_C: begin mul_a = hd_ext; mul_b = c_q; end
			MUL_HD_D: begin mul_a = hd_ext; mul_b = d_q; end
			MUL_HD_Q: begin mul_a = hd_ext; mul_b = q_q; end
			default:  begin mul_a = hn_q;   mul_b = d_q; end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Magnitudes of the raw fraction
	logic signed [SW-1:0] num_neg, den_neg;
	logic [MW-1:0]        num_mag, den_mag;
	assign num_neg = -num_q;
	assign den_neg = -den_q;
	assign num_mag = num_q[SW-1] ? num_neg[MW-1:0] : num_q[MW-1:0];
	assign den_mag = den_q[SW-1] ? den_neg[MW-1:0] : den_q[MW-1:0];

	// Binary GCD step
	logic [MW-1:0] ga_n, gb_n, gsum, g_next;
	logic [KW-1:0] gk_n;
	always_comb begin
		ga_n = ga_q;
		gb_n = gb_q;
		gk_n = gk_q;
		priority if (!ga_q[0] && !gb_q[0]) begin
			ga_n = ga_q >> 1;
			gb_n = gb_q >> 1;
			gk_n = gk_q + KW'(1);
		end else if (!ga_q[0]) begin
			ga_n = ga_q >> 1;
		end else if (!gb_q[0]) begin
			gb_n = gb_q >> 1;
		end else if (ga_q >= gb_q) begin
			ga_n = (ga_q - gb_q) >> 1;
		end else begin
			gb_n = (gb_q - ga_q) >> 1;
		end
	end
	assign gsum   = (ga_q | gb_q) << gk_q;
	assign g_next = (gsum == '0) ? MW'(1) : gsum;

	// Restoring division step, both quotients at once
	logic [MW:0] tn, td, tn_sub, td_sub;
	logic        gen, ged;
	assign tn     = {rn_q, qn_q[MW-1]};
	assign td     = {rd_q, qd_q[MW-1]};
	assign tn_sub = tn - {1'b0, g_q};
	assign td_sub = td - {1'b0, g_q};
	assign gen    = tn >= {1'b0, g_q};
	assign ged    = td >= {1'b0, g_q};

	// Fit test and new held value
	logic [MW-1:0]       lim;
	logic                neg, fits, upd;
	logic signed [W-1:0] qn_neg, new_hn;
	logic [W-2:0]        new_hd;
	assign lim    = MW'(1) << (W - 1);
	assign neg    = (qn_q != '0) && sign_q;
	assign fits   = (qd_q < lim) && (neg ? (qn_q <= lim) : (qn_q < lim));
	assign upd    = (act_q != ACT_NONE) && fits;
	assign qn_neg = -signed'(qn_q[W-1:0]);
	assign new_hn = upd ? (neg ? qn_neg : signed'(qn_q[W-1:0])) : hn_q;
	assign new_hd = upd ? qd_q[W-2:0] : hd_q;

	// Capture item and run arithmetic
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q <= action_t'(action);
			c_q   <= in_numerator;
			d_q   <= in_denominator;
			q_q   <= divisor;
		end
		if (cmd.mul_en) prod_q <= mul_p;
		unique case (cmd.num_op)
			NUM_PROD: num_q <= SW'(prod_q);
			NUM_ADD:  num_q <= num_q + SW'(prod_q);
			NUM_HN:   num_q <= SW'(hn_q);
			NUM_C:    num_q <= SW'(c_q);
			default:  num_q <= num_q;
		endcase
		unique case (cmd.den_op)
			DEN_PROD: den_q <= SW'(prod_q);
			DEN_D:    den_q <= SW'(d_q);
			default:  den_q <= den_q;
		endcase
		if (cmd.gcd_init) begin
			mn_q   <= num_mag;
			md_q   <= den_mag;
			ga_q   <= num_mag;
			gb_q   <= den_mag;
			gk_q   <= '0;
			sign_q <= num_q[SW-1] ^ den_q[SW-1];
		end else if (cmd.gcd_step) begin
			ga_q <= ga_n;
			gb_q <= gb_n;
			gk_q <= gk_n;
		end
		if (cmd.div_init) begin
			g_q   <= g_next;
			qn_q  <= mn_q;
			qd_q  <= md_q;
			rn_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rn_q  <= gen ? tn_sub[MW-1:0] : tn[MW-1:0];
			rd_q  <= ged ? td_sub[MW-1:0] : td[MW-1:0];
			qn_q  <= {qn_q[MW-2:0], gen};
			qd_q  <= {qd_q[MW-2:0], ged};
			cnt_q <= cnt_q + KW'(1);
		end
		if (cmd.commit) begin
			sum_numerator    <= new_hn;
			sum_denominator  <= new_hd;
			zero_denominator <= (new_hd == '0);
			overflow         <= (act_q != ACT_NONE) && !fits;
		end
	end

	// Hold the running fraction and the output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hn_q        <= '0;
			hd_q        <= (W-1)'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				hn_q        <= new_hn;
				hd_q        <= new_hd;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status.act      = act_q;
	assign status.gcd_done = (ga_q == '0) || (gb_q == '0);
	assign status.div_done = (cnt_q == KW'(MW));
	assign status.out_free = !out_valid_q || out_ready;
endmodule

// File: sv/rfa_controller.sv
`include "reduced_fraction_accumulator_assert.svh"
module rfa_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rfa_pkg::rfa_status_t status,
	output rfa_pkg::rfa_cmd_t    cmd
);
	import rfa_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_M0   = 10'b0000000010,
		S_M1   = 10'b0000000100,
		S_M2   = 10'b0000001000,
		S_M3   = 10'b0000010000,
		S_PREP = 10'b0000100000,
		S_GCD  = 10'b0001000000,
		S_GSET = 10'b0010000000,
		S_DIV  = 10'b0100000000,
		S_DONE = 10'b1000000000
	} state_t;

	state_t state_q, state_n;

	assign in_ready = (state_q == S_IDLE);

	// Sequence the operation
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_n     = S_M0;
				end
			end
			S_M0: begin
				unique case (status.act)
					ACT_ADD: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = MUL_HN_D;
						state_n     = S_M1;
					end
					ACT_DIV: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = MUL_HD_Q;
						state_n     = S_M1;
					end
					ACT_LOAD: begin
						cmd.num_op = NUM_C;
						cmd.den_op = DEN_D;
						state_n    = S_PREP;
					end
					default: state_n = S_DONE;
				endcase
			end
			S_M1: begin
				if (status.act == ACT_ADD) begin
					cmd.num_op  = NUM_PROD;
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = MUL_HD_C;
					state_n     = S_M2;
				end else begin
					cmd.num_op = NUM_HN;
					cmd.den_op = DEN_PROD;
					state_n    = S_PREP;
				end
			end
			S_M2: begin
				cmd.num_op  = NUM_ADD;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_HD_D;
				state_n     = S_M3;
			end
			S_M3: begin
				cmd.den_op = DEN_PROD;
				state_n    = S_PREP;
			end
			S_PREP: begin
				cmd.gcd_init = 1'b1;
				state_n      = S_GCD;
			end
			S_GCD: begin
				if (status.gcd_done) state_n = S_GSET;
				else cmd.gcd_step = 1'b1;
			end
			S_GSET: begin
				cmd.div_init = 1'b1;
				state_n      = S_DIV;
			end
			S_DIV: begin
				if (status.div_done) state_n = S_DONE;
				else cmd.div_step = 1'b1;
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_n    = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_n;
	end

	`RFA_ASSERT_NOW(a_commit_free, cmd.commit, status.out_free, "commit while output full")
	`RFA_ASSERT_NEXT(a_gcd_exit, (state_q == S_GCD) && status.gcd_done, state_q == S_GSET, "gcd exit")
	`RFA_ASSERT_NEXT(a_accept_start, cmd.load_in, state_q == S_M0, "accept did not start")
endmodule

// File: sv/reduced_fraction_accumulator.sv
// Sequence: load, the multiply steps for the action, the binary GCD loop on 64-bit
//   magnitudes, then 64 restoring division steps and the commit.
// Throughput: one item at a time; the GCD loop and division sequencer set it.
// Action code 3 passes from accept through S_M0 and S_DONE to its output beat. A new
//   item is taken only once the result is registered and the controller is back in S_IDLE.
// Reset (arst_n low, asynchronous): held sum 0/1, controller idle, no output beat.
module reduced_fraction_accumulator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             action,
	input  logic signed [rfa_pkg::VALUE_WIDTH-1:0] in_numerator,
	input  logic signed [rfa_pkg::VALUE_WIDTH-1:0] in_denominator,
	input  logic signed [rfa_pkg::VALUE_WIDTH-1:0] divisor,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [rfa_pkg::VALUE_WIDTH-1:0] sum_numerator,
	output logic [rfa_pkg::VALUE_WIDTH-2:0]        sum_denominator,
	output logic                                   zero_denominator,
	output logic                                   overflow
);
	import rfa_pkg::*;

	rfa_cmd_t    cmd;
	rfa_status_t status;

	// Sequence control
	rfa_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic and held sum
	rfa_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.action           (action),
		.in_numerator     (in_numerator),
		.in_denominator   (in_denominator),
		.divisor          (divisor),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.sum_numerator    (sum_numerator),
		.sum_denominator  (sum_denominator),
		.zero_denominator (zero_denominator),
		.overflow         (overflow)
	);
endmodule
